@@ rtl/signed_decimal_field_formatter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Signed decimal field formatter assertion macros
// Shared concurrent assertion forms used by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_CORE_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset
`define SDFF_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SDFF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SDFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sdff_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed decimal field formatter package
// Widths, register indexes, ASCII codes and arithmetic constants.
// ----------------------------------------------------------------------------
package sdff_pkg;

   // Payload widths
   localparam int unsigned NumberW   = 32;
   localparam int unsigned CharW     = 8;

   // Field arithmetic and configuration widths
   localparam int unsigned FieldW    = 7;
   localparam int unsigned PrecW     = 6;
   localparam int unsigned CsrDataW  = 7;
   localparam int unsigned CsrIndexW = 3;

   // Digit store geometry
   localparam int unsigned MaxDigits = 10;
   localparam int unsigned DigitW    = 4;
   localparam int unsigned DigitCntW = 4;

   // Default field limit
   localparam int unsigned MaxFieldDefault = 64;

   // Divide by ten through the reciprocal: q = (n * Recip10) >> Recip10Shift
   localparam logic [NumberW-1:0] Recip10      = 32'hCCCC_CCCD;
   localparam int unsigned        Recip10Shift = 35;
   localparam int unsigned        ProdW        = 2 * NumberW;
   localparam int unsigned        QuotW        = ProdW - Recip10Shift;

   // ASCII codes
   localparam logic [CharW-1:0] ChZero  = 8'h30;
   localparam logic [CharW-1:0] ChMinus = 8'h2D;
   localparam logic [CharW-1:0] ChPlus  = 8'h2B;
   localparam logic [CharW-1:0] ChSpace = 8'h20;

   // Configuration register indexes
   typedef enum logic [CsrIndexW-1:0] {
      CSR_MIN_WIDTH        = 3'd0,
      CSR_DIGIT_PRECISION  = 3'd1,
      CSR_PRECISION_ENABLE = 3'd2,
      CSR_ZERO_PAD         = 3'd3,
      CSR_LEFT_JUSTIFY     = 3'd4,
      CSR_SPACE_SIGN       = 3'd5,
      CSR_PLUS_SIGN        = 3'd6
   } csr_index_type;

endpackage

@@ rtl/sdff_channels_if.sv @@
// ----------------------------------------------------------------------------
// Signed decimal field formatter channels
// Valid/ready channels for the input numbers and the output characters.
// ----------------------------------------------------------------------------
interface sdff_req_if;
   import sdff_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [NumberW-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface sdff_rsp_if;
   import sdff_pkg::*;

   logic             valid;
   logic             ready;
   logic [CharW-1:0] character;
   logic             last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ rtl/signed_decimal_field_formatter_core.sv @@
// ----------------------------------------------------------------------------
// Signed decimal field formatter core
// Renders each signed 32-bit number as a printf %d field, one ASCII character
// per output transfer, with the final character of each field flagged.
// ----------------------------------------------------------------------------
// One number is handled at a time. After the input transfer the magnitude is
// split into decimal digits by one shared 32x32 reciprocal multiplier, each
// digit through a multiply state (S_MUL) and a digit state (S_DIG), 1 to 10
// digits; then S_SETUP lays out the field boundaries, then the characters
// leave one per cycle while the output is not held by backpressure (1 to
// MAX_FIELD of them). The last character may still wait in the output
// register while the next number is accepted. The user must write
// configuration through the csr port only while the block is idle; the block
// itself does not enforce this. Widths above MAX_FIELD saturate and longer
// fields are cut to MAX_FIELD.
// ----------------------------------------------------------------------------
`include "signed_decimal_field_formatter_core_macros.svh"

module signed_decimal_field_formatter_core #(
   parameter int unsigned MAX_FIELD = sdff_pkg::MaxFieldDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   sdff_req_if.sink                       req_if,
   sdff_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [sdff_pkg::CsrIndexW-1:0] csr_index,
   input  logic [sdff_pkg::CsrDataW-1:0]  csr_wdata
);
   import sdff_pkg::*;

   localparam int unsigned        PosW      = $clog2(MAX_FIELD + 1);
   localparam logic [FieldW-1:0]  MaxFieldW = FieldW'(MAX_FIELD);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIG,
      S_SETUP,
      S_EMIT
   } state_type;

   // Configuration registers
   logic [FieldW-1:0] cfg_min_width_ff;
   logic [PrecW-1:0]  cfg_prec_ff;
   logic              cfg_prec_en_ff;
   logic              cfg_zero_ff;
   logic              cfg_left_ff;
   logic              cfg_space_ff;
   logic              cfg_plus_ff;

   // Sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [NumberW-1:0]   mag_ff, mag_in;
   logic [ProdW-1:0]     prod_ff, prod_in;
   logic [DigitCntW-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [PosW-1:0]      pos_ff, pos_in;
   logic [DigitCntW-1:0] dptr_ff, dptr_in;
   logic [FieldW-1:0]    lpad_ff, lpad_in;
   logic [FieldW-1:0]    bsign_ff, bsign_in;
   logic [FieldW-1:0]    bzero_ff, bzero_in;
   logic [FieldW-1:0]    bdig_ff, bdig_in;
   logic [PosW-1:0]      total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharW-1:0]     rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [DigitW-1:0]    digits_ff [MaxDigits];

   // Digit extraction
   logic [QuotW-1:0]  quot;
   logic [DigitW-1:0] quot_x10_lo;
   logic [DigitW-1:0] rem;
   logic              dig_we;

   // Field layout
   logic              has_sign;
   logic [CharW-1:0]  sign_char;
   logic [FieldW-1:0] dc7, prec7, zeros_p, body_p, width7, zeros_f, body_f, fill, lpad_c;
   logic [FieldW-1:0] total7;
   logic              zfill;

   // Character selection
   logic [FieldW-1:0] p7;
   logic [CharW-1:0]  emit_char;
   logic              emit_is_digit;
   logic              emit_last;
   logic              out_free;

   // Quotient and remainder of the current magnitude by ten
   assign quot        = prod_ff[ProdW-1:Recip10Shift];
   assign quot_x10_lo = DigitW'({quot[DigitW-1:0], 3'b000}) + DigitW'({quot[DigitW-1:0], 1'b0});
   assign rem         = mag_ff[DigitW-1:0] - quot_x10_lo;

   // Lay out sign, zero fill and padding from the digit count
   always_comb begin
      has_sign  = neg_ff | cfg_plus_ff | cfg_space_ff;
      sign_char = neg_ff ? ChMinus : (cfg_plus_ff ? ChPlus : ChSpace);
      dc7       = FieldW'(cnt_ff);
      prec7     = FieldW'(cfg_prec_ff);
      zeros_p   = (cfg_prec_en_ff && (prec7 > dc7)) ? (prec7 - dc7) : '0;
      body_p    = FieldW'(has_sign) + zeros_p + dc7;
      width7    = (cfg_min_width_ff > MaxFieldW) ? MaxFieldW : cfg_min_width_ff;
      zfill     = cfg_zero_ff && !cfg_prec_en_ff && !cfg_left_ff && (width7 > body_p);
      zeros_f   = zfill ? (zeros_p + (width7 - body_p)) : zeros_p;
      body_f    = zfill ? width7 : body_p;
      fill      = (width7 > body_f) ? (width7 - body_f) : '0;
      lpad_c    = cfg_left_ff ? '0 : fill;
      total7    = body_f + fill;
   end

   // Pick the character at the current position
   always_comb begin
      p7            = FieldW'(pos_ff);
      emit_is_digit = 1'b0;
      if (p7 < lpad_ff) begin
         emit_char = ChSpace;
      end else if (p7 < bsign_ff) begin
         emit_char = sign_char;
      end else if (p7 < bzero_ff) begin
         emit_char = ChZero;
      end else if (p7 < bdig_ff) begin
         emit_char     = ChZero + CharW'(digits_ff[dptr_ff]);
         emit_is_digit = 1'b1;
      end else begin
         emit_char = ChSpace;
      end
      emit_last = (PosW'(pos_ff + 1'b1) == total_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      dptr_in      = dptr_ff;
      lpad_in      = lpad_ff;
      bsign_in     = bsign_ff;
      bzero_in     = bzero_ff;
      bdig_in      = bdig_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      dig_we       = 1'b0;

      // Drop the output once the transfer completes
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               neg_in   = req_if.number[NumberW-1];
               mag_in   = req_if.number[NumberW-1] ? (NumberW'(0) - NumberW'(req_if.number))
                                                   : NumberW'(req_if.number);
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = ProdW'(mag_ff) * ProdW'(Recip10);
            state_in = S_DIG;
         end
         S_DIG: begin
            dig_we = 1'b1;
            mag_in = NumberW'(quot);
            cnt_in = cnt_ff + 1'b1;
            if ((quot == '0) || (cnt_ff == DigitCntW'(MaxDigits - 1))) begin
               state_in = S_SETUP;
            end else begin
               state_in = S_MUL;
            end
         end
         S_SETUP: begin
            lpad_in  = lpad_c;
            bsign_in = lpad_c + FieldW'(has_sign);
            bzero_in = lpad_c + FieldW'(has_sign) + zeros_f;
            bdig_in  = lpad_c + FieldW'(has_sign) + zeros_f + dc7;
            total_in = (total7 > MaxFieldW) ? PosW'(MaxFieldW) : PosW'(total7);
            pos_in   = '0;
            dptr_in  = cnt_ff - 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_char;
               rsp_last_in  = emit_last;
               if (emit_is_digit) begin
                  dptr_in = dptr_ff - 1'b1;
               end
               if (emit_last) begin
                  pos_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      dptr_ff     <= dptr_in;
      lpad_ff     <= lpad_in;
      bsign_ff    <= bsign_in;
      bzero_ff    <= bzero_in;
      bdig_ff     <= bdig_in;
      total_ff    <= total_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (dig_we) begin
         digits_ff[cnt_ff] <= rem;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_width_ff <= '0;
         cfg_prec_ff      <= '0;
         cfg_prec_en_ff   <= 1'b0;
         cfg_zero_ff      <= 1'b0;
         cfg_left_ff      <= 1'b0;
         cfg_space_ff     <= 1'b0;
         cfg_plus_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_WIDTH:        cfg_min_width_ff <= csr_wdata[FieldW-1:0];
            CSR_DIGIT_PRECISION:  cfg_prec_ff      <= csr_wdata[PrecW-1:0];
            CSR_PRECISION_ENABLE: cfg_prec_en_ff   <= csr_wdata[0];
            CSR_ZERO_PAD:         cfg_zero_ff      <= csr_wdata[0];
            CSR_LEFT_JUSTIFY:     cfg_left_ff      <= csr_wdata[0];
            CSR_SPACE_SIGN:       cfg_space_ff     <= csr_wdata[0];
            CSR_PLUS_SIGN:        cfg_plus_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Drive the channels; hold off input transfers during reset
   assign req_if.ready     = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.character = rsp_char_ff;
   assign rsp_if.last_char = rsp_last_ff;

   // Checks
   `SDFF_ASSERT_ALWAYS(a_digit_count_bound, clock, reset,
      cnt_ff <= DigitCntW'(MaxDigits), "digit count beyond digit store depth")
   `SDFF_ASSERT_IMPLY(a_idle_pos_zero, clock, reset,
      state_ff == S_IDLE, pos_ff == '0, "character position not cleared while idle")
   `SDFF_ASSERT_IMPLY(a_emit_in_field, clock, reset,
      state_ff == S_EMIT, pos_ff < total_ff, "character position past field length")
   `SDFF_ASSERT_IMPLY(a_digit_ptr_valid, clock, reset,
      (state_ff == S_EMIT) && emit_is_digit, dptr_ff < cnt_ff, "digit read outside stored digits")
   `SDFF_ASSERT_NEXT(a_last_returns_idle, clock, reset,
      (state_ff == S_EMIT) && out_free && emit_last,
      (state_ff == S_IDLE) && rsp_valid_ff && rsp_last_ff, "last character did not end the field")

endmodule
